[hw/rtl/iad_pkg.sv]
package iad_pkg;

   localparam int DATA_BITS = 64;
   localparam int CHAR_BITS = 8;
   localparam int VALUE_WIDTH_DEF = 64;

   localparam logic [CHAR_BITS-1:0] ASCII_ZERO  = 8'd48;
   localparam logic [CHAR_BITS-1:0] ASCII_NINE  = 8'd57;
   localparam logic [CHAR_BITS-1:0] ASCII_MINUS = 8'd45;

   typedef logic [DATA_BITS-1:0] data_type;
   typedef logic [CHAR_BITS-1:0] char_type;

endpackage

[hw/rtl/iad_req_if.sv]
interface iad_req_if import iad_pkg::*; ();
   logic     valid;
   logic     ready;
   data_type value;
   logic     is_signed;

   modport source (output valid, output value, output is_signed, input ready);
   modport sink (input valid, input value, input is_signed, output ready);
endinterface

[hw/rtl/iad_rsp_if.sv]
interface iad_rsp_if import iad_pkg::*; ();
   logic     valid;
   logic     ready;
   char_type char_code;
   logic     last;

   modport source (output valid, output char_code, output last, input ready);
   modport sink (input valid, input char_code, input last, output ready);
endinterface

[hw/rtl/int_to_decimal_ascii.sv]
// Converts the low VALUE_WIDTH bits of each request to decimal ASCII text, most
// significant character first, one character per response, last set on the final
// one; in signed mode a negative value is led by '-'. One request is handled at a
// time. A single shift-and-add-3 unit runs once per value bit, then leading zero
// digits are dropped one per cycle, then one character leaves per cycle while the
// response receiver is ready.
module int_to_decimal_ascii import iad_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input logic        clock,
   input logic        reset,
   iad_req_if.sink    req_if,
   iad_rsp_if.source  rsp_if
);

   // decimal digits of 2^VALUE_WIDTH - 1
   localparam int NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int BCD_BITS   = 4 * NUM_DIGITS;
   localparam int CNT_W      = $clog2(VALUE_WIDTH);
   localparam int DIG_W      = $clog2(NUM_DIGITS + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_SKIP = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic [BCD_BITS-1:0]    bcd_ff, bcd_in, bcd_adj;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [DIG_W-1:0]       left_ff, left_in;
   logic                   neg_ff, neg_in;

   logic [VALUE_WIDTH-1:0] raw;
   logic                   req_neg;
   logic [3:0]             top_digit;
   logic                   req_take, rsp_take;

   assign raw       = req_if.value[VALUE_WIDTH-1:0];
   assign req_neg   = req_if.is_signed & raw[VALUE_WIDTH-1];
   assign top_digit = bcd_ff[BCD_BITS-1 -: 4];

   assign req_if.ready     = (state_ff == ST_IDLE);
   assign req_take         = req_if.valid & req_if.ready;
   assign rsp_if.valid     = (state_ff == ST_EMIT);
   assign rsp_take         = rsp_if.valid & rsp_if.ready;
   assign rsp_if.char_code = neg_ff ? ASCII_MINUS : (ASCII_ZERO + {4'b0000, top_digit});
   assign rsp_if.last      = ~neg_ff & (left_ff == DIG_W'(1));

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      logic [3:0] d;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         d = bcd_ff[4*i +: 4];
         bcd_adj[4*i +: 4] = (d >= 4'd5) ? (d + 4'd3) : d;
      end
   end

   always_comb begin
      state_in = state_ff;
      mag_in   = mag_ff;
      bcd_in   = bcd_ff;
      cnt_in   = cnt_ff;
      left_in  = left_ff;
      neg_in   = neg_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               mag_in   = req_neg ? (~raw + VALUE_WIDTH'(1)) : raw;
               neg_in   = req_neg;
               bcd_in   = '0;
               cnt_in   = CNT_W'(VALUE_WIDTH - 1);
               left_in  = DIG_W'(NUM_DIGITS);
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in = {bcd_adj[BCD_BITS-2:0], mag_ff[VALUE_WIDTH-1]};
            mag_in = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (top_digit == 4'd0 && left_ff != DIG_W'(1)) begin
               bcd_in  = {bcd_ff[BCD_BITS-5:0], 4'd0};
               left_in = left_ff - DIG_W'(1);
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_take) begin
               if (neg_ff) begin
                  neg_in = 1'b0;
               end else begin
                  bcd_in  = {bcd_ff[BCD_BITS-5:0], 4'd0};
                  left_in = left_ff - DIG_W'(1);
                  if (left_ff == DIG_W'(1)) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         left_ff  <= '0;
         neg_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         left_ff  <= left_in;
         neg_ff   <= neg_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_if.valid && req_if.ready))
      else $error("request taken while response pending");

   a_start_conv: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_CONV && cnt_ff == CNT_W'(VALUE_WIDTH - 1)))
      else $error("conversion did not start after request");

   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.char_code == ASCII_MINUS ||
                        (rsp_if.char_code >= ASCII_ZERO && rsp_if.char_code <= ASCII_NINE)))
      else $error("character out of range");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rsp_if.last) |=> req_if.ready)
      else $error("not ready after final character");

   a_left_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SKIP || state_ff == ST_EMIT) |-> (left_ff != '0))
      else $error("digit count ran out");

endmodule
